// ===== sv/sst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants of the sorted server table.
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // fixed field widths
   localparam int POS_W       = 6;
   localparam int COUNT_W     = 7;
   localparam int LIMIT_W     = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic OP_NOTIFY = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [1:0] KIND_UPDATED  = 2'd0;
   localparam logic [1:0] KIND_INSERTED = 2'd1;
   localparam logic [1:0] KIND_DROPPED  = 2'd2;
   localparam logic [1:0] KIND_READ     = 2'd3;

   localparam logic [1:0] CLS_CLOSED = 2'd0;
   localparam logic [1:0] CLS_IDLE   = 2'd1;
   localparam logic [1:0] CLS_BUSY   = 2'd2;
   localparam logic [1:0] CLS_FULL   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BUSY_LIMIT = 2'd1;

   localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 16'd1000;
   localparam logic [LIMIT_W-1:0] BUSY_LIMIT_RESET = 16'd2000;

   typedef struct packed {
      logic [31:0]        server_id;
      logic signed [31:0] key;
      logic [15:0]        port;
      logic [1:0]         cls;
   } entry_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] idle_limit;
      logic [LIMIT_W-1:0] busy_limit;
   } cfg_type;

   typedef struct packed {
      logic               opcode;
      logic [31:0]        server_id;
      logic signed [31:0] server_ip;
      logic [15:0]        server_port;
      logic               online;
      logic [15:0]        load;
      logic [POS_W-1:0]   read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] entry_count;
      logic               entry_valid;
      entry_type          entry;
   } result_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_addr;
   } mem_cmd_type;

endpackage

// ===== sv/sst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_if
// Request, response and register write channels of the sorted server table.
// ----------------------------------------------------------------------------
interface sst_req_if;
   import sst_pkg::*;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [31:0]        server_id;
   logic signed [31:0] server_ip;
   logic [15:0]        server_port;
   logic               online;
   logic [15:0]        load;
   logic [POS_W-1:0]   read_index;

   modport source (output valid, opcode, server_id, server_ip, server_port, online,
                   load, read_index, input ready);
   modport sink (input valid, opcode, server_id, server_ip, server_port, online,
                 load, read_index, output ready);
endinterface

interface sst_rsp_if;
   import sst_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [POS_W-1:0]   position;
   logic [COUNT_W-1:0] entry_count;
   logic               entry_valid;
   logic [31:0]        entry_server_id;
   logic signed [31:0] entry_ip;
   logic [15:0]        entry_port;
   logic [1:0]         entry_state;

   modport source (output valid, result_kind, position, entry_count, entry_valid,
                   entry_server_id, entry_ip, entry_port, entry_state, input ready);
   modport sink (input valid, result_kind, position, entry_count, entry_valid,
                 entry_server_id, entry_ip, entry_port, entry_state, output ready);
endinterface

interface sst_csr_if;
   import sst_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LIMIT_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/sst_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_store
// Entry memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sst_store (
   input  logic                 clock,
   input  sst_pkg::mem_cmd_type cmd,
   output sst_pkg::entry_type   rd_data
);
   import sst_pkg::*;

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_data_ff <= mem_ff[cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: linear lower-bound scan with one key comparator, then a
// one-entry-per-cycle shift through the memory and the final write.
// ----------------------------------------------------------------------------
module sst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  sst_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sst_pkg::req_type     req,
   output logic                 res_valid,
   input  logic                 res_ready,
   output sst_pkg::result_type  res,
   output sst_pkg::mem_cmd_type mem_cmd,
   input  sst_pkg::entry_type   rd_data
);
   import sst_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_READ   = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_PLACE  = 7'b0001000,
      ST_SHIFT  = 7'b0010000,
      ST_WRITE  = 7'b0100000,
      ST_RESULT = 7'b1000000
   } state_type;

   localparam int CMP_W = CNT_W + POS_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);

   state_type          state_ff, state_in;
   entry_type          ent_ff, ent_in;
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   sh_ff, sh_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               match_ff, match_in;
   logic [1:0]         kind_ff, kind_in;
   result_type         res_ff, res_in;

   logic [CNT_W-1:0]   pos_inc, sh_dec1, sh_dec2, last_pos, last_dec, place_pos;
   logic [1:0]         cls;
   logic               key_less;

   // status class of the incoming notify
   always_comb begin
      if (!req.online) begin
         cls = CLS_CLOSED;
      end else if (req.load < cfg.idle_limit) begin
         cls = CLS_IDLE;
      end else if (req.load < cfg.busy_limit) begin
         cls = CLS_BUSY;
      end else begin
         cls = CLS_FULL;
      end
   end

   // the one key comparator
   assign key_less  = rd_data.key < ent_ff.key;

   assign pos_inc   = pos_ff + 1'b1;
   assign sh_dec1   = sh_ff - 1'b1;
   assign sh_dec2   = sh_ff - 2'd2;
   // last slot the insert may use; a full table drops its largest key
   assign last_pos  = (cnt_ff >= DEPTH_C) ? LAST_C : cnt_ff;
   assign last_dec  = last_pos - 1'b1;
   assign place_pos = (pos_ff > last_pos) ? last_pos : pos_ff;

   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      sh_in    = sh_ff;
      cnt_in   = cnt_ff;
      match_in = match_ff;
      kind_in  = kind_ff;
      res_in   = res_ff;

      mem_cmd.wr_en   = 1'b0;
      mem_cmd.wr_addr = pos_ff[IDX_W-1:0];
      mem_cmd.wr_data = ent_ff;
      mem_cmd.rd_addr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req.opcode == OP_READ) begin
               mem_cmd.rd_addr = IDX_W'(req.read_index);
            end
            if (req_valid) begin
               if (req.opcode == OP_READ) begin
                  idx_in   = req.read_index;
                  state_in = ST_READ;
               end else begin
                  ent_in.server_id = req.server_id;
                  ent_in.key       = req.server_ip;
                  ent_in.port      = req.server_port;
                  ent_in.cls       = cls;
                  pos_in   = '0;
                  match_in = 1'b0;
                  state_in = (cnt_ff == '0) ? ST_PLACE : ST_SCAN;
               end
            end
         end
         ST_READ: begin
            res_in.kind        = KIND_READ;
            res_in.position    = idx_ff;
            res_in.entry_count = COUNT_W'(cnt_ff);
            if (CMP_W'(idx_ff) < CMP_W'(cnt_ff)) begin
               res_in.entry_valid = 1'b1;
               res_in.entry       = rd_data;
            end else begin
               res_in.entry_valid = 1'b0;
               res_in.entry       = '0;
            end
            state_in = ST_RESULT;
         end
         ST_SCAN: begin
            // rd_data holds the entry at pos_ff; prefetch the next one
            mem_cmd.rd_addr = pos_inc[IDX_W-1:0];
            if (key_less) begin
               pos_in = pos_inc;
               if (pos_inc == cnt_ff) begin
                  state_in = ST_PLACE;
               end
            end else begin
               match_in = (rd_data.key == ent_ff.key);
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (match_ff) begin
               kind_in  = KIND_UPDATED;
               state_in = ST_WRITE;
            end else begin
               kind_in = (cnt_ff >= DEPTH_C) ? KIND_DROPPED : KIND_INSERTED;
               pos_in  = place_pos;
               cnt_in  = last_pos + 1'b1;
               if (last_pos > place_pos) begin
                  mem_cmd.rd_addr = last_dec[IDX_W-1:0];
                  sh_in    = last_pos;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_SHIFT: begin
            // move entry sh-1 up to sh while fetching sh-2
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = sh_ff[IDX_W-1:0];
            mem_cmd.wr_data = rd_data;
            if (sh_ff > pos_inc) begin
               mem_cmd.rd_addr = sh_dec2[IDX_W-1:0];
               sh_in = sh_dec1;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mem_cmd.wr_en      = 1'b1;
            res_in.kind        = kind_ff;
            res_in.position    = POS_W'(pos_ff);
            res_in.entry_count = COUNT_W'(cnt_ff);
            res_in.entry_valid = 1'b1;
            res_in.entry       = ent_ff;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      ent_ff   <= ent_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      sh_ff    <= sh_in;
      match_ff <= match_in;
      kind_ff  <= kind_in;
      res_ff   <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESULT);
   assign res       = res_ff;

endmodule

// ===== sv/sorted_server_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_server_table
// Server entries kept in ascending signed key order, insert or update and read.
// ----------------------------------------------------------------------------
// A read passes from the transfer through the READ and RESULT states into the
// output register. A notify scans the table from index 0 with a single key
// comparator, one stored entry per cycle through the one read port of the entry
// memory, then, for a new key, moves each entry above the insert point up one
// slot per cycle. The next request is taken once the result has moved into the
// output register, so a result may wait there while the next item runs. The
// entry memory needs no clearing after reset; of the table contents only the
// entry count is reset.
module sorted_server_table (
   input logic        clock,
   input logic        reset,
   sst_req_if.sink    req_in,
   sst_rsp_if.source  rsp_out,
   sst_csr_if.sink    csr_in
);
   import sst_pkg::*;

   cfg_type     cfg_ff;
   req_type     req;
   result_type  res;
   result_type  rsp_data_ff;
   logic        rsp_valid_ff;
   logic        res_valid;
   logic        res_ready;
   mem_cmd_type mem_cmd;
   entry_type   rd_data;

   // register writes
   assign csr_in.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_limit <= IDLE_LIMIT_RESET;
         cfg_ff.busy_limit <= BUSY_LIMIT_RESET;
      end else if (csr_in.valid) begin
         case (csr_in.index)
            REG_IDLE_LIMIT: cfg_ff.idle_limit <= csr_in.data;
            REG_BUSY_LIMIT: cfg_ff.busy_limit <= csr_in.data;
            default: begin
            end
         endcase
      end
   end

   assign req.opcode      = req_in.opcode;
   assign req.server_id   = req_in.server_id;
   assign req.server_ip   = req_in.server_ip;
   assign req.server_port = req_in.server_port;
   assign req.online      = req_in.online;
   assign req.load        = req_in.load;
   assign req.read_index  = req_in.read_index;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_in.valid),
      .req_ready (req_in.ready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_cmd   (mem_cmd),
      .rd_data   (rd_data)
   );

   sst_store u_store (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   // output register decouples the sequencer from the response side
   assign res_ready = !rsp_valid_ff || rsp_out.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_out.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_out.valid           = rsp_valid_ff;
   assign rsp_out.result_kind     = rsp_data_ff.kind;
   assign rsp_out.position        = rsp_data_ff.position;
   assign rsp_out.entry_count     = rsp_data_ff.entry_count;
   assign rsp_out.entry_valid     = rsp_data_ff.entry_valid;
   assign rsp_out.entry_server_id = rsp_data_ff.entry.server_id;
   assign rsp_out.entry_ip        = rsp_data_ff.entry.key;
   assign rsp_out.entry_port      = rsp_data_ff.entry.port;
   assign rsp_out.entry_state     = rsp_data_ff.entry.cls;

endmodule

// ===== tb/sorted_server_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_server_table_test
// Self-checking bench for the sorted server table. A directed table of
// requests comes first, then random notify and read traffic under several
// threshold settings. Every result is checked against a typed expected result
// or a table model kept in step with each accepted request.
// ----------------------------------------------------------------------------
module sorted_server_table_test;
   import sst_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASE_COUNT    = 7;
   localparam int PHASE_ITEMS    = 100;
   localparam int MAX_REPORTS    = 10;

   localparam logic [31:0] EXTREME_KEYS [6] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE, 32'h8000_0001, 32'h0, 32'hFFFF_FFFF
   };

   typedef struct {
      req_type    req;
      bit         typed;
      result_type want;
   } directed_row_type;

   logic clock;
   logic reset;

   sst_req_if req_bus ();
   sst_rsp_if rsp_bus ();
   sst_csr_if csr_bus ();

   sorted_server_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus),
      .csr_in  (csr_bus)
   );

   entry_type          model_table [TABLE_DEPTH];
   int                 model_count      = 0;
   logic [LIMIT_W-1:0] model_idle_limit = IDLE_LIMIT_RESET;
   logic [LIMIT_W-1:0] model_busy_limit = BUSY_LIMIT_RESET;

   result_type       pending_results [$];
   directed_row_type directed_rows [$];
   int               failures    = 0;
   int               idle_cycles = 0;
   int               req_stretch = 0;
   int               rsp_stretch = 0;
   bit               req_calm;
   bit               rsp_calm;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // applies one request to the table model and returns the result it gives
   function automatic result_type table_apply(req_type r);
      result_type res;
      entry_type  item;
      int         pos;
      int         last;
      res = '0;
      res.entry_count = COUNT_W'(model_count);
      if (r.opcode == OP_READ) begin
         res.kind     = KIND_READ;
         res.position = r.read_index;
         if (int'(r.read_index) < model_count) begin
            res.entry_valid = 1'b1;
            res.entry       = model_table[r.read_index];
         end
         return res;
      end
      item.server_id = r.server_id;
      item.key       = r.server_ip;
      item.port      = r.server_port;
      if (!r.online)
         item.cls = CLS_CLOSED;
      else if (r.load < model_idle_limit)
         item.cls = CLS_IDLE;
      else if (r.load < model_busy_limit)
         item.cls = CLS_BUSY;
      else
         item.cls = CLS_FULL;
      pos = 0;
      while (pos < model_count && $signed(model_table[pos].key) < $signed(r.server_ip))
         pos++;
      if (pos < model_count && model_table[pos].key == r.server_ip) begin
         res.kind = KIND_UPDATED;
      end else begin
         last = model_count;
         if (last >= TABLE_DEPTH) begin
            // full table: the largest key falls off the end
            last     = TABLE_DEPTH - 1;
            res.kind = KIND_DROPPED;
         end else begin
            res.kind = KIND_INSERTED;
         end
         if (pos > last)
            pos = last;
         for (int i = last; i > pos; i--)
            model_table[i] = model_table[i - 1];
         model_count = last + 1;
      end
      model_table[pos] = item;
      res.position     = POS_W'(pos);
      res.entry_count  = COUNT_W'(model_count);
      res.entry_valid  = 1'b1;
      res.entry        = item;
      return res;
   endfunction

   function automatic req_type notify_req(logic [31:0] id, logic [31:0] ip,
                                          logic [15:0] port, logic online,
                                          logic [15:0] load);
      req_type r;
      r             = '0;
      r.opcode      = OP_NOTIFY;
      r.server_id   = id;
      r.server_ip   = ip;
      r.server_port = port;
      r.online      = online;
      r.load        = load;
      return r;
   endfunction

   function automatic req_type read_req(logic [POS_W-1:0] idx);
      req_type r;
      r            = '0;
      r.opcode     = OP_READ;
      r.read_index = idx;
      return r;
   endfunction

   function automatic result_type typed_result(logic [1:0] kind, int pos, int count,
                                               logic valid, logic [31:0] id,
                                               logic [31:0] ip, logic [15:0] port,
                                               logic [1:0] cls);
      result_type res;
      res.kind            = kind;
      res.position        = POS_W'(pos);
      res.entry_count     = COUNT_W'(count);
      res.entry_valid     = valid;
      res.entry.server_id = id;
      res.entry.key       = ip;
      res.entry.port      = port;
      res.entry.cls       = cls;
      return res;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      int      near;
      r.opcode      = ($urandom_range(0, 9) < 3) ? OP_READ : OP_NOTIFY;
      r.server_id   = $urandom;
      r.server_port = 16'($urandom);
      r.online      = ($urandom_range(0, 4) != 0);
      r.read_index  = POS_W'($urandom);
      // reuse stored keys often so that updates keep coming
      pick = $urandom_range(0, 99);
      if (pick < 25 && model_count > 0)
         r.server_ip = model_table[$urandom_range(0, model_count - 1)].key;
      else if (pick < 40)
         r.server_ip = EXTREME_KEYS[$urandom_range(0, 5)];
      else
         r.server_ip = $urandom;
      // loads around the thresholds, at the extremes or anywhere in range
      pick = $urandom_range(0, 99);
      if (pick < 25)
         near = int'(model_idle_limit) + int'($urandom_range(0, 2)) - 1;
      else if (pick < 50)
         near = int'(model_busy_limit) + int'($urandom_range(0, 2)) - 1;
      else if (pick < 60)
         near = $urandom_range(0, 1) ? 65535 : 0;
      else
         near = $urandom_range(0, 65535);
      r.load = 16'(near);
      return r;
   endfunction

   function automatic int draw_wait(inout int stretch, inout bit calm);
      if (stretch == 0) begin
         stretch = $urandom_range(8, 40);
         calm    = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic string result_text(result_type r);
      return $sformatf("kind=%0d pos=%0d count=%0d valid=%0d id=%h ip=%h port=%h state=%0d",
                       r.kind, r.position, r.entry_count, r.entry_valid,
                       r.entry.server_id, r.entry.key, r.entry.port, r.entry.cls);
   endfunction

   function automatic string diff_fields(result_type e, result_type a);
      string bad;
      bad = "";
      if (e.kind !== a.kind)                       bad = {bad, " result_kind"};
      if (e.position !== a.position)               bad = {bad, " position"};
      if (e.entry_count !== a.entry_count)         bad = {bad, " entry_count"};
      if (e.entry_valid !== a.entry_valid)         bad = {bad, " entry_valid"};
      if (e.entry.server_id !== a.entry.server_id) bad = {bad, " entry_server_id"};
      if (e.entry.key !== a.entry.key)             bad = {bad, " entry_ip"};
      if (e.entry.port !== a.entry.port)           bad = {bad, " entry_port"};
      if (e.entry.cls !== a.entry.cls)             bad = {bad, " entry_state"};
      return bad;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%0t: %0s", $realtime, msg);
   endtask

   task automatic send_request(input req_type r, input bit typed, input result_type want);
      int         gap;
      result_type predicted;
      gap = draw_wait(req_stretch, req_calm);
      repeat (gap) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.opcode      = r.opcode;
      req_bus.server_id   = r.server_id;
      req_bus.server_ip   = r.server_ip;
      req_bus.server_port = r.server_port;
      req_bus.online      = r.online;
      req_bus.load        = r.load;
      req_bus.read_index  = r.read_index;
      req_bus.valid       = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      predicted = table_apply(r);
      pending_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] reg_index,
                              input logic [LIMIT_W-1:0] value);
      csr_bus.index = reg_index;
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      if (reg_index == REG_IDLE_LIMIT)
         model_idle_limit = value;
      else
         model_busy_limit = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // hold off the sender until every outstanding result is back
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // result receiver with random stalls
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         stall = draw_wait(rsp_stretch, rsp_calm);
         repeat (stall) begin
            rsp_bus.ready = 1'b0;
            @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      result_type seen;
      result_type wanted;
      string      bad;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.kind            = rsp_bus.result_kind;
         seen.position        = rsp_bus.position;
         seen.entry_count     = rsp_bus.entry_count;
         seen.entry_valid     = rsp_bus.entry_valid;
         seen.entry.server_id = rsp_bus.entry_server_id;
         seen.entry.key       = rsp_bus.entry_ip;
         seen.entry.port      = rsp_bus.entry_port;
         seen.entry.cls       = rsp_bus.entry_state;
         if (pending_results.size() == 0) begin
            note_failure({"unexpected result: ", result_text(seen)});
         end else begin
            wanted = pending_results.pop_front();
            bad    = diff_fields(wanted, seen);
            if (bad != "")
               note_failure({"mismatch in", bad, "\n   expected ", result_text(wanted),
                             "\n   actual   ", result_text(seen)});
         end
      end
   end

   // counts cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sorted_server_table_test: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [LIMIT_W-1:0] phase_idle [PHASE_COUNT];
      logic [LIMIT_W-1:0] phase_busy [PHASE_COUNT];
      directed_row_type   row;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_NOTIFY;
      req_bus.server_id   = '0;
      req_bus.server_ip   = '0;
      req_bus.server_port = '0;
      req_bus.online      = 1'b0;
      req_bus.load        = '0;
      req_bus.read_index  = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = REG_IDLE_LIMIT;
      csr_bus.data        = '0;

      // phase 0 runs on the reset thresholds, the last one returns to them
      phase_idle = '{IDLE_LIMIT_RESET, 16'h0000, 16'hFFFF, 16'd3000,
                     16'($urandom), 16'($urandom), IDLE_LIMIT_RESET};
      phase_busy = '{BUSY_LIMIT_RESET, 16'h0000, 16'hFFFF, 16'd100,
                     16'($urandom), 16'($urandom), BUSY_LIMIT_RESET};

      // empty table reads, then extreme keys with typed results
      directed_rows.push_back('{read_req(0), 1'b1,
         typed_result(KIND_READ, 0, 0, 1'b0, 0, 0, 0, CLS_CLOSED)});
      directed_rows.push_back('{read_req(63), 1'b1,
         typed_result(KIND_READ, 63, 0, 1'b0, 0, 0, 0, CLS_CLOSED)});
      directed_rows.push_back('{notify_req(32'd1, 32'h0, 16'd80, 1'b0, 16'd0), 1'b1,
         typed_result(KIND_INSERTED, 0, 1, 1'b1, 32'd1, 32'h0, 16'd80, CLS_CLOSED)});
      directed_rows.push_back('{notify_req(32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b1,
                                           16'd0), 1'b1,
         typed_result(KIND_INSERTED, 1, 2, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
                      CLS_IDLE)});
      directed_rows.push_back('{notify_req(32'h0, 32'h8000_0000, 16'h0, 1'b1, 16'hFFFF), 1'b1,
         typed_result(KIND_INSERTED, 0, 3, 1'b1, 32'h0, 32'h8000_0000, 16'h0, CLS_FULL)});
      // loads on both sides of each threshold, keys whose difference overflows
      directed_rows.push_back('{notify_req(32'hA5A5_A5A5, 32'h4000_0000, 16'h5A5A, 1'b1,
                                           16'd999), 1'b0, '0});
      directed_rows.push_back('{notify_req(32'h5A5A_5A5A, 32'hC000_0000, 16'hA5A5, 1'b1,
                                           16'd1000), 1'b0, '0});
      directed_rows.push_back('{notify_req(32'd2, 32'hFFFF_FFFF, 16'd443, 1'b1, 16'd1999),
                                1'b0, '0});
      directed_rows.push_back('{notify_req(32'd3, 32'h1, 16'd8080, 1'b1, 16'd2000), 1'b0, '0});
      // keys 0 and 7FFF_FFFF again: update in place; 7FFF_FFFE and 8000_0001 are new
      directed_rows.push_back('{notify_req(32'd4, 32'h0, 16'd81, 1'b1, 16'd1500), 1'b0, '0});
      directed_rows.push_back('{notify_req(32'd5, 32'h7FFF_FFFF, 16'd1, 1'b0, 16'hFFFF),
                                1'b0, '0});
      directed_rows.push_back('{notify_req(32'd6, 32'h7FFF_FFFE, 16'd2, 1'b1, 16'd1), 1'b0, '0});
      directed_rows.push_back('{notify_req(32'd7, 32'h8000_0001, 16'd3, 1'b1, 16'd0), 1'b0, '0});
      // reads inside and beyond the valid count
      directed_rows.push_back('{read_req(0), 1'b0, '0});
      directed_rows.push_back('{read_req(4), 1'b0, '0});
      directed_rows.push_back('{read_req(8), 1'b0, '0});
      directed_rows.push_back('{read_req(9), 1'b0, '0});
      directed_rows.push_back('{read_req(63), 1'b0, '0});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.req, row.typed, row.want);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            drain_results();
            if ($urandom_range(0, 1)) begin
               write_limit(REG_IDLE_LIMIT, phase_idle[p]);
               write_limit(REG_BUSY_LIMIT, phase_busy[p]);
            end else begin
               write_limit(REG_BUSY_LIMIT, phase_busy[p]);
               write_limit(REG_IDLE_LIMIT, phase_idle[p]);
            end
         end
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_request(random_req(), 1'b0, '0);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("sorted_server_table_test: PASS");
      else
         $display("sorted_server_table_test: FAIL");
      $finish;
   end

endmodule
